@@ hdl/arpc_pkg.sv @@
// Shared constants, opcodes and event codes for the ARP cache core.
package arpc_pkg;

    // Table sizes and result limit
    localparam int REQ_SLOTS   = 16;
    localparam int ENTRY_SLOTS = 16;
    localparam int MAX_RESULTS = 16;

    localparam int REQ_IW  = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
    localparam int ENT_IW  = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int SCAN_W  = (REQ_IW > ENT_IW) ? REQ_IW : ENT_IW;
    localparam int EVCNT_W = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int AGE_W   = 16;
    localparam int SENDS_W = 4;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_LIMIT = 2'd1;
    localparam logic [AGE_W-1:0]     TIMEOUT_RESET  = 16'd10;
    localparam logic [SENDS_W-1:0]   LIMIT_RESET    = 4'd7;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUEUE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_SEND    = 3'd0;
    localparam logic [KIND_W-1:0] EV_DROP    = 3'd1;
    localparam logic [KIND_W-1:0] EV_HIT     = 3'd2;
    localparam logic [KIND_W-1:0] EV_MISS    = 3'd3;
    localparam logic [KIND_W-1:0] EV_RELEASE = 3'd4;
    localparam logic [KIND_W-1:0] EV_IGNORED = 3'd5;
    localparam logic [KIND_W-1:0] EV_FULL    = 3'd6;

    // Saturation limits
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [SENDS_W-1:0] SENDS_MAX = '1;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } event_t;

endpackage

@@ hdl/arp_cache_with_request_retry_core.sv @@
// ARP cache with pending request retry: sequencer, slot tables and output buffering.
// Tick scans the request slots then the entry slots; queue scans requests, add both
// tables, lookup entries, each then a final step; a new item is taken only in idle.
// The shared compare/age unit visits one slot per cycle unless the scan is stalled,
// and output back-pressure stalls the scan only when two results wait.
// Reset clears all valid bits at once and loads timeout 10, send limit 7.
module arp_cache_with_request_retry_core
    import arpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [IP_W-1:0]       ip_address,
    input  logic [MAC_W-1:0]      mac_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     event_kind,
    output logic [IP_W-1:0]       out_ip,
    output logic [MAC_W-1:0]      out_mac,
    output logic                  last_event
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REQ   = 3'd1;
    localparam logic [2:0] S_ENT   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    localparam logic [SCAN_W-1:0] REQ_LAST = SCAN_W'(REQ_SLOTS - 1);
    localparam logic [SCAN_W-1:0] ENT_LAST = SCAN_W'(ENTRY_SLOTS - 1);

    // Configuration registers
    logic [AGE_W-1:0]   timeout_reg;
    logic [SENDS_W-1:0] limit_reg;

    // Slot tables
    logic [REQ_SLOTS-1:0]   req_valid_reg;
    logic [IP_W-1:0]        req_ip_reg    [REQ_SLOTS];
    logic [SENDS_W-1:0]     req_sends_reg [REQ_SLOTS];
    logic [AGE_W-1:0]       req_age_reg   [REQ_SLOTS];
    logic [ENTRY_SLOTS-1:0] ent_valid_reg;
    logic [IP_W-1:0]        ent_ip_reg    [ENTRY_SLOTS];
    logic [MAC_W-1:0]       ent_mac_reg   [ENTRY_SLOTS];
    logic [AGE_W-1:0]       ent_age_reg   [ENTRY_SLOTS];

    // Sequencer registers
    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic [SCAN_W-1:0]  idx_reg, idx_next;
    logic [EVCNT_W-1:0] evcnt_reg, evcnt_next;

    // Scan findings
    logic              rmatch_reg, rmatch_next;
    logic [REQ_IW-1:0] rmatch_idx_reg, rmatch_idx_next;
    logic              rfree_reg, rfree_next;
    logic [REQ_IW-1:0] rfree_idx_reg, rfree_idx_next;
    logic              ematch_reg, ematch_next;
    logic [ENT_IW-1:0] ematch_idx_reg, ematch_idx_next;
    logic              efree_reg, efree_next;
    logic [ENT_IW-1:0] efree_idx_reg, efree_idx_next;
    logic [ENT_IW-1:0] oldest_idx_reg, oldest_idx_next;
    logic [AGE_W-1:0]  oldest_age_reg, oldest_age_next;
    logic [MAC_W-1:0]  hit_mac_reg, hit_mac_next;

    // Hold and output stages
    logic   hold_valid_reg, hold_valid_next;
    event_t hold_reg, hold_next;
    logic   out_valid_reg, out_valid_next;
    event_t out_reg, out_next;
    logic   out_last_reg, out_last_next;

    // Slot reads at the scan pointer
    logic [REQ_IW-1:0]  r_idx;
    logic [ENT_IW-1:0]  e_idx;
    logic               rq_vld, en_vld;
    logic [IP_W-1:0]    rq_ip, en_ip;
    logic [SENDS_W-1:0] rq_sends;
    logic [AGE_W-1:0]   rq_age, en_age;
    logic [MAC_W-1:0]   en_mac;
    logic [AGE_W-1:0]   age_inc_r, age_inc_e;
    logic               to_r, to_e;

    // Emit path
    logic   out_free, can_emit, advance;
    logic   ev_fire, ev_push;
    event_t ev;

    // Table write controls
    logic               rq_we, rq_wip_en, rv_we, rv_wd;
    logic [REQ_IW-1:0]  rq_wa, rv_wa;
    logic [SENDS_W-1:0] rq_wsends;
    logic [AGE_W-1:0]   rq_wage;
    logic               ee_we, ee_wip_en, nv_we, nv_wd;
    logic [ENT_IW-1:0]  ee_wa, nv_wa, add_slot;
    logic [AGE_W-1:0]   ee_wage;

    assign r_idx     = idx_reg[REQ_IW-1:0];
    assign e_idx     = idx_reg[ENT_IW-1:0];
    assign rq_vld    = req_valid_reg[r_idx];
    assign rq_ip     = req_ip_reg[r_idx];
    assign rq_sends  = req_sends_reg[r_idx];
    assign rq_age    = req_age_reg[r_idx];
    assign en_vld    = ent_valid_reg[e_idx];
    assign en_ip     = ent_ip_reg[e_idx];
    assign en_mac    = ent_mac_reg[e_idx];
    assign en_age    = ent_age_reg[e_idx];

    // Saturating age step and timeout compare
    assign age_inc_r = (rq_age == AGE_MAX) ? AGE_MAX : rq_age + 1'b1;
    assign age_inc_e = (en_age == AGE_MAX) ? AGE_MAX : en_age + 1'b1;
    assign to_r      = age_inc_r >= timeout_reg;
    assign to_e      = age_inc_e >= timeout_reg;

    // A step may push a result only if the hold slot can empty into the output
    assign out_free  = !out_valid_reg || out_ready;
    assign can_emit  = !hold_valid_reg || out_free;
    assign advance   = can_emit;
    assign ev_push   = ev_fire && (evcnt_reg < EVCNT_W'(MAX_RESULTS));

    assign add_slot  = ematch_reg ? ematch_idx_reg :
                       (efree_reg ? efree_idx_reg : oldest_idx_reg);

    // Per-step event and table updates
    always_comb
    begin
        ev_fire   = 1'b0;
        ev        = '{kind: EV_SEND, ip: ip_reg, mac: '0};
        rq_we     = 1'b0;
        rq_wip_en = 1'b0;
        rq_wa     = r_idx;
        rq_wsends = rq_sends;
        rq_wage   = age_inc_r;
        rv_we     = 1'b0;
        rv_wa     = r_idx;
        rv_wd     = 1'b0;
        ee_we     = 1'b0;
        ee_wip_en = 1'b0;
        ee_wa     = e_idx;
        ee_wage   = age_inc_e;
        nv_we     = 1'b0;
        nv_wa     = e_idx;
        nv_wd     = 1'b0;
        if (advance)
        begin
            unique case (state_reg)
                S_REQ:
                begin
                    // Tick ages each live request, resends or drops it on timeout
                    if (op_reg == OP_TICK && rq_vld)
                    begin
                        rq_we = 1'b1;
                        if (to_r)
                        begin
                            ev_fire = 1'b1;
                            ev.ip   = rq_ip;
                            if (rq_sends >= limit_reg)
                            begin
                                ev.kind = EV_DROP;
                                rv_we   = 1'b1;
                            end
                            else
                            begin
                                ev.kind   = EV_SEND;
                                rq_wsends = (rq_sends == SENDS_MAX) ? SENDS_MAX
                                                                    : rq_sends + 1'b1;
                                rq_wage   = '0;
                            end
                        end
                    end
                end
                S_ENT:
                begin
                    // Tick ages each live entry and expires it on timeout
                    if (op_reg == OP_TICK && en_vld)
                    begin
                        ee_we = 1'b1;
                        if (to_e)
                        begin
                            nv_we = 1'b1;
                        end
                    end
                end
                S_FIN:
                begin
                    priority if (op_reg == OP_QUEUE)
                    begin
                        if (!rmatch_reg)
                        begin
                            ev_fire = 1'b1;
                            if (!rfree_reg)
                            begin
                                ev.kind = EV_FULL;
                            end
                            else if (limit_reg == '0)
                            begin
                                ev.kind = EV_DROP;
                            end
                            else
                            begin
                                ev.kind   = EV_SEND;
                                rq_we     = 1'b1;
                                rq_wip_en = 1'b1;
                                rq_wa     = rfree_idx_reg;
                                rq_wsends = SENDS_W'(1);
                                rq_wage   = '0;
                                rv_we     = 1'b1;
                                rv_wa     = rfree_idx_reg;
                                rv_wd     = 1'b1;
                            end
                        end
                    end
                    else if (op_reg == OP_ADD)
                    begin
                        ev_fire = 1'b1;
                        if (!rmatch_reg)
                        begin
                            ev.kind = EV_IGNORED;
                        end
                        else
                        begin
                            ev.kind   = EV_RELEASE;
                            ev.mac    = mac_reg;
                            ee_we     = 1'b1;
                            ee_wip_en = 1'b1;
                            ee_wa     = add_slot;
                            ee_wage   = '0;
                            nv_we     = 1'b1;
                            nv_wa     = add_slot;
                            nv_wd     = 1'b1;
                            rv_we     = 1'b1;
                            rv_wa     = rmatch_idx_reg;
                            rv_wd     = 1'b0;
                        end
                    end
                    else
                    begin
                        ev_fire = 1'b1;
                        ev.kind = ematch_reg ? EV_HIT : EV_MISS;
                        ev.mac  = ematch_reg ? hit_mac_reg : '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, scan findings and result buffering
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        evcnt_next      = evcnt_reg;
        rmatch_next     = rmatch_reg;
        rmatch_idx_next = rmatch_idx_reg;
        rfree_next      = rfree_reg;
        rfree_idx_next  = rfree_idx_reg;
        ematch_next     = ematch_reg;
        ematch_idx_next = ematch_idx_reg;
        efree_next      = efree_reg;
        efree_idx_next  = efree_idx_reg;
        oldest_idx_next = oldest_idx_reg;
        oldest_age_next = oldest_age_reg;
        hit_mac_next    = hit_mac_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        // New result: earlier held one moves on as a middle result
        if (ev_push)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = ev;
            evcnt_next      = evcnt_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next    = '0;
                    evcnt_next  = '0;
                    rmatch_next = 1'b0;
                    rfree_next  = 1'b0;
                    ematch_next = 1'b0;
                    efree_next  = 1'b0;
                    state_next  = (opcode == OP_LOOKUP) ? S_ENT : S_REQ;
                end
            end
            S_REQ:
            begin
                if (advance)
                begin
                    if (rq_vld && rq_ip == ip_reg && !rmatch_reg)
                    begin
                        rmatch_next     = 1'b1;
                        rmatch_idx_next = r_idx;
                    end
                    if (!rq_vld && !rfree_reg)
                    begin
                        rfree_next     = 1'b1;
                        rfree_idx_next = r_idx;
                    end
                    if (idx_reg == REQ_LAST)
                    begin
                        idx_next   = '0;
                        state_next = (op_reg == OP_QUEUE) ? S_FIN : S_ENT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_ENT:
            begin
                if (advance)
                begin
                    if (en_vld && en_ip == ip_reg && !ematch_reg)
                    begin
                        ematch_next     = 1'b1;
                        ematch_idx_next = e_idx;
                        hit_mac_next    = en_mac;
                    end
                    if (!en_vld && !efree_reg)
                    begin
                        efree_next     = 1'b1;
                        efree_idx_next = e_idx;
                    end
                    // Oldest entry: largest age, first slot wins ties
                    if (idx_reg == '0 || en_age > oldest_age_reg)
                    begin
                        oldest_idx_next = e_idx;
                        oldest_age_next = en_age;
                    end
                    if (idx_reg == ENT_LAST)
                    begin
                        idx_next   = '0;
                        state_next = (op_reg == OP_TICK) ? S_DRAIN : S_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (advance)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The held result is the final one of this item
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            evcnt_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            limit_reg      <= LIMIT_RESET;
            req_valid_reg  <= '0;
            ent_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            evcnt_reg      <= evcnt_next;
            if (cfg_wr_en && cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data[AGE_W-1:0];
            end
            if (cfg_wr_en && cfg_index == REG_SEND_LIMIT)
            begin
                limit_reg <= cfg_data[SENDS_W-1:0];
            end
            if (rv_we)
            begin
                req_valid_reg[rv_wa] <= rv_wd;
            end
            if (nv_we)
            begin
                ent_valid_reg[nv_wa] <= nv_wd;
            end
        end
    end

    // Payload registers and table contents
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg  <= opcode;
            ip_reg  <= ip_address;
            mac_reg <= mac_address;
        end
        idx_reg        <= idx_next;
        rmatch_reg     <= rmatch_next;
        rmatch_idx_reg <= rmatch_idx_next;
        rfree_reg      <= rfree_next;
        rfree_idx_reg  <= rfree_idx_next;
        ematch_reg     <= ematch_next;
        ematch_idx_reg <= ematch_idx_next;
        efree_reg      <= efree_next;
        efree_idx_reg  <= efree_idx_next;
        oldest_idx_reg <= oldest_idx_next;
        oldest_age_reg <= oldest_age_next;
        hit_mac_reg    <= hit_mac_next;
        hold_reg       <= hold_next;
        out_reg        <= out_next;
        out_last_reg   <= out_last_next;
        if (rq_we)
        begin
            req_sends_reg[rq_wa] <= rq_wsends;
            req_age_reg[rq_wa]   <= rq_wage;
        end
        if (rq_wip_en)
        begin
            req_ip_reg[rq_wa] <= ip_reg;
        end
        if (ee_we)
        begin
            ent_age_reg[ee_wa] <= ee_wage;
        end
        if (ee_wip_en)
        begin
            ent_ip_reg[ee_wa]  <= ip_reg;
            ent_mac_reg[ee_wa] <= mac_reg;
        end
    end

    // Ports
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign event_kind = out_reg.kind;
    assign out_ip     = out_reg.ip;
    assign out_mac    = out_reg.mac;
    assign last_event = out_last_reg;

    // Checks
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held result left behind at idle");

    a_fin_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !hold_valid_reg)
        else $error("result held before the final step");

    a_evcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        evcnt_reg <= EVCNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && hold_valid_reg && out_free) |=>
        (out_valid_reg && out_last_reg))
        else $error("final result not marked last");

endmodule

@@ bench/tb_arp_cache_with_request_retry_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ARP cache core with request retry.
module tb_arp_cache_with_request_retry_core;
    import arpc_pkg::*;

    localparam int CLK_HALF       = 5;
    // Longest scan (add) plus margin; covers items that give no result
    localparam int DRAIN_CYCLES   = REQ_SLOTS + ENTRY_SLOTS + 8;
    // Worst gap without a transfer is a sender gap, drain, two writes, a full scan
    // and a receiver stall, well below this limit
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int POOL_SIZE      = 24;
    localparam int NUM_PHASES     = 5;
    localparam int NUM_ROWS       = 35;

    // Register indexes past the end of the list, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam bit ROW_ITEM  = 1'b0;
    localparam bit ROW_CFG   = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam bit CHECKED   = 1'b1;

    localparam logic [IP_W-1:0]  IP_ONES  = '1;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic              last;
    } arp_event_t;

    // One directed row: either an item or a register write
    typedef struct packed {
        logic                  is_cfg;
        logic [OP_W-1:0]       op;
        logic [IP_W-1:0]       ip;
        logic [MAC_W-1:0]      mac;
        logic                  typed;
        logic [KIND_W-1:0]     kind;
        logic [MAC_W-1:0]      emac;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } stim_row_t;

    // DUT inputs, known from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic [OP_W-1:0]       opcode      = OP_TICK;
    logic [IP_W-1:0]       ip_address  = '0;
    logic [MAC_W-1:0]      mac_address = '0;
    logic                  out_ready   = 1'b1;
    logic                  in_ready;
    logic                  out_valid;
    logic [KIND_W-1:0]     event_kind;
    logic [IP_W-1:0]       out_ip;
    logic [MAC_W-1:0]      out_mac;
    logic                  last_event;

    // Predicted table contents and register values
    logic [AGE_W-1:0]   retry_timeout;
    logic [SENDS_W-1:0] retry_limit;
    logic               pend_valid [REQ_SLOTS];
    logic [IP_W-1:0]    pend_ip    [REQ_SLOTS];
    logic [SENDS_W-1:0] pend_sends [REQ_SLOTS];
    logic [AGE_W-1:0]   pend_age   [REQ_SLOTS];
    logic               cache_valid [ENTRY_SLOTS];
    logic [IP_W-1:0]    cache_ip    [ENTRY_SLOTS];
    logic [MAC_W-1:0]   cache_mac   [ENTRY_SLOTS];
    logic [AGE_W-1:0]   cache_age   [ENTRY_SLOTS];

    // Events of the current item, and the events still owed by the DUT
    arp_event_t step_buf [MAX_RESULTS];
    int         step_n;
    arp_event_t awaited_events [$];

    logic [IP_W-1:0] ip_pool [POOL_SIZE];
    bit  steady_tail = 1'b0;
    bit  calm        = 1'b0;
    int  mismatches  = 0;
    int  items_sent  = 0;
    int  results_seen = 0;
    int  settings_used = 1;
    int  op_seen   [4];
    int  kind_seen [8];
    int  idle_run  = 0;

    // Random phases: register setting, length, and whether tables are driven full
    logic [AGE_W-1:0]   phase_timeout [NUM_PHASES] = '{16'd4, 16'd1, 16'hFFFF, 16'd0, 16'd7};
    logic [SENDS_W-1:0] phase_limit   [NUM_PHASES] = '{4'd3, 4'd15, 4'd2, 4'd3, 4'd15};
    int                 phase_len     [NUM_PHASES] = '{50, 50, 90, 50, 45};

    // Directed table; on item rows the register fields are unused, on
    // register rows the item fields are unused
    stim_row_t directed_rows [NUM_ROWS] = '{
        // empty tables after reset
        {ROW_ITEM, OP_LOOKUP, 32'h0, 48'h0, CHECKED, EV_MISS, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_ADD, IP_ONES, MAC_ONES, CHECKED, EV_IGNORED, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        // address extremes, duplicate queue, add and lookup
        {ROW_ITEM, OP_QUEUE, 32'h0, 48'h0, CHECKED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_QUEUE, IP_ONES, 48'h0, CHECKED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_QUEUE, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_ADD, 32'h0, MAC_ONES, CHECKED, EV_RELEASE, MAC_ONES, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_LOOKUP, 32'h0, 48'h0, CHECKED, EV_HIT, MAC_ONES, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_ADD, IP_ONES, 48'h0, CHECKED, EV_RELEASE, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_LOOKUP, IP_ONES, 48'h0, CHECKED, EV_HIT, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_ADD, IP_ONES, 48'h5555_5555_5555, CHECKED, EV_IGNORED, 48'h0,
         REG_TIMEOUT, 16'h0},
        // timeout of one tick, single send
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'd1},
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_SEND_LIMIT, 16'd1},
        {ROW_ITEM, OP_QUEUE, 32'h0A00_0001, 48'h0, CHECKED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0A00_0001, 48'h0, CHECKED, EV_DROP, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_LOOKUP, 32'h0, 48'h0, CHECKED, EV_MISS, 48'h0, REG_TIMEOUT, 16'h0},
        // zero timeout and zero send limit: request dropped at once
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'd0},
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_SEND_LIMIT, 16'd0},
        {ROW_ITEM, OP_QUEUE, 32'h0102_0304, 48'h0, CHECKED, EV_DROP, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        // unknown indexes, timeout 2, then a limit written with stray upper bits
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_SPARE_2, 16'hFFFF},
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_SPARE_3, 16'hFFFF},
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'd2},
        {ROW_CFG, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_SEND_LIMIT, 16'hFFF3},
        // two requests retried together, one resolved, the other dropped
        {ROW_ITEM, OP_QUEUE, 32'hC0A8_0001, 48'h0, CHECKED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_QUEUE, 32'hAAAA_AAAA, 48'h0, CHECKED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_ADD, 32'hC0A8_0001, 48'h1234_5678_9ABC, CHECKED, EV_RELEASE,
         48'h1234_5678_9ABC, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_TICK, 32'h0, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0},
        {ROW_ITEM, OP_LOOKUP, 32'hC0A8_0001, 48'h0, PREDICTED, EV_SEND, 48'h0, REG_TIMEOUT, 16'h0}
    };

    arp_cache_with_request_retry_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .out_ip      (out_ip),
        .out_mac     (out_mac),
        .last_event  (last_event)
    );

    always #(CLK_HALF) clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void log_event(input logic [KIND_W-1:0] kind,
                                      input logic [IP_W-1:0] ip,
                                      input logic [MAC_W-1:0] mac);
        arp_event_t ev;
        ev.kind = kind;
        ev.ip   = ip;
        ev.mac  = mac;
        ev.last = 1'b0;
        // events past the result limit are lost, their effect is not
        if (step_n < MAX_RESULTS)
        begin
            step_buf[step_n] = ev;
            step_n++;
        end
    endfunction

    function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + 1'b1;
    endfunction

    function automatic int find_pending(input logic [IP_W-1:0] ip);
        int i;
        for (i = 0; i < REQ_SLOTS; i++)
            if (pend_valid[i] && pend_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // Resend a request, or drop it once its sends reach the limit
    function automatic void retry_or_drop(input int s);
        if (pend_sends[s] >= retry_limit)
        begin
            pend_valid[s] = 1'b0;
            log_event(EV_DROP, pend_ip[s], '0);
        end
        else
        begin
            log_event(EV_SEND, pend_ip[s], '0);
            if (pend_sends[s] != SENDS_MAX)
                pend_sends[s] = pend_sends[s] + 1'b1;
            pend_age[s] = '0;
        end
    endfunction

    // Apply one item to the predicted tables and collect its events
    function automatic void resolve_events(input logic [OP_W-1:0] op,
                                           input logic [IP_W-1:0] ip,
                                           input logic [MAC_W-1:0] mac);
        int i;
        int r;
        int slot;
        step_n = 0;
        case (op)
            OP_TICK:
            begin
                for (i = 0; i < REQ_SLOTS; i++)
                begin
                    if (pend_valid[i])
                    begin
                        pend_age[i] = age_step(pend_age[i]);
                        if (pend_age[i] >= retry_timeout)
                            retry_or_drop(i);
                    end
                end
                for (i = 0; i < ENTRY_SLOTS; i++)
                begin
                    if (cache_valid[i])
                    begin
                        cache_age[i] = age_step(cache_age[i]);
                        if (cache_age[i] >= retry_timeout)
                            cache_valid[i] = 1'b0;
                    end
                end
            end
            OP_QUEUE:
            begin
                if (find_pending(ip) < 0)
                begin
                    slot = -1;
                    for (i = 0; i < REQ_SLOTS; i++)
                        if (!pend_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        log_event(EV_FULL, ip, '0);
                    else
                    begin
                        pend_valid[slot] = 1'b1;
                        pend_ip[slot]    = ip;
                        pend_sends[slot] = '0;
                        pend_age[slot]   = '0;
                        retry_or_drop(slot);
                    end
                end
            end
            OP_ADD:
            begin
                r = find_pending(ip);
                if (r < 0)
                    log_event(EV_IGNORED, ip, '0);
                else
                begin
                    // existing entry, else lowest free, else oldest
                    slot = -1;
                    for (i = 0; i < ENTRY_SLOTS; i++)
                        if (slot < 0 && cache_valid[i] && cache_ip[i] == ip)
                            slot = i;
                    for (i = 0; i < ENTRY_SLOTS; i++)
                        if (slot < 0 && !cache_valid[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        slot = 0;
                        for (i = 1; i < ENTRY_SLOTS; i++)
                            if (cache_age[i] > cache_age[slot])
                                slot = i;
                    end
                    cache_valid[slot] = 1'b1;
                    cache_ip[slot]    = ip;
                    cache_mac[slot]   = mac;
                    cache_age[slot]   = '0;
                    pend_valid[r]     = 1'b0;
                    log_event(EV_RELEASE, ip, mac);
                end
            end
            default:
            begin
                slot = -1;
                for (i = 0; i < ENTRY_SLOTS; i++)
                    if (slot < 0 && cache_valid[i] && cache_ip[i] == ip)
                        slot = i;
                if (slot < 0)
                    log_event(EV_MISS, ip, '0);
                else
                    log_event(EV_HIT, ip, cache_mac[slot]);
            end
        endcase
    endfunction

    // Append one event to those still owed by the DUT
    function automatic void owe_event(input arp_event_t ev);
        awaited_events = {awaited_events, ev};
    endfunction

    // ---------------------------------------------------------------
    // Driving tasks
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Register write; the enable is dropped for a cycle so writes never merge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_TIMEOUT:    retry_timeout = val;
            REG_SEND_LIMIT: retry_limit   = val[SENDS_W-1:0];
            default:        ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off input until every awaited event is back and the scan is over
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!steady_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Present one item, wait for its transfer, then queue what it should cause
    task automatic drive_item(input logic [OP_W-1:0] op,
                              input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac,
                              input logic typed,
                              input logic [KIND_W-1:0] kind,
                              input logic [MAC_W-1:0] emac);
        arp_event_t ev;
        int i;
        in_valid    <= 1'b1;
        opcode      <= op;
        ip_address  <= ip;
        mac_address <= mac;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        items_sent++;
        op_seen[op]++;
        resolve_events(op, ip, mac);
        if (typed)
        begin
            ev.kind = kind;
            ev.ip   = ip;
            ev.mac  = emac;
            ev.last = 1'b1;
            owe_event(ev);
        end
        else
        begin
            for (i = 0; i < step_n; i++)
            begin
                ev      = step_buf[i];
                ev.last = (i == step_n - 1);
                owe_event(ev);
            end
        end
    endtask

    // Random item: mostly addresses from a small pool so that queue, add and
    // lookup meet each other; a few items are pure noise
    task automatic pick_item(input bit fill, output logic [OP_W-1:0] op,
                             output logic [IP_W-1:0] ip, output logic [MAC_W-1:0] mac);
        logic [63:0] wide;
        int roll;
        int live;
        int k;
        int i;
        wide = {$urandom, $urandom};
        mac  = wide[MAC_W-1:0];
        ip   = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            op = OP_W'($urandom_range(0, 3));
            ip = $urandom;
        end
        else if (roll < (fill ? 46 : 38))
            op = OP_QUEUE;
        else if (roll < (fill ? 86 : 60))
        begin
            op = OP_ADD;
            live = 0;
            for (i = 0; i < REQ_SLOTS; i++)
                if (pend_valid[i])
                    live++;
            // usually resolve a request that is really pending
            if (live != 0 && $urandom_range(0, 99) < 85)
            begin
                k = $urandom_range(0, live - 1);
                for (i = 0; i < REQ_SLOTS; i++)
                begin
                    if (pend_valid[i])
                    begin
                        if (k == 0)
                            ip = pend_ip[i];
                        k--;
                    end
                end
            end
        end
        else if (roll < (fill ? 96 : 78))
        begin
            op = OP_LOOKUP;
            if ($urandom_range(0, 6) == 0)
                ip = $urandom;
        end
        else
        begin
            op = OP_TICK;
            ip = $urandom;
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int row;
        int ph;
        int n;
        int i;
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;

        retry_timeout = TIMEOUT_RESET;
        retry_limit   = LIMIT_RESET;
        for (i = 0; i < REQ_SLOTS; i++)
            pend_valid[i] = 1'b0;
        for (i = 0; i < ENTRY_SLOTS; i++)
            cache_valid[i] = 1'b0;
        for (i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        for (i = 0; i < 4; i++)
            op_seen[i] = 0;
        for (i = 0; i < 8; i++)
            kind_seen[i] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < NUM_ROWS; row++)
        begin
            if (directed_rows[row].is_cfg)
            begin
                wait_idle();
                write_reg(directed_rows[row].reg_idx, directed_rows[row].reg_val);
                settings_used++;
            end
            else
            begin
                sender_gap();
                drive_item(directed_rows[row].op, directed_rows[row].ip,
                           directed_rows[row].mac, directed_rows[row].typed,
                           directed_rows[row].kind, directed_rows[row].emac);
            end
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            write_reg(REG_TIMEOUT, phase_timeout[ph]);
            write_reg(REG_SEND_LIMIT, {{(CFG_DATA_W - SENDS_W){1'b0}}, phase_limit[ph]});
            settings_used++;
            steady_tail = (ph == NUM_PHASES - 1);
            for (n = 0; n < phase_len[ph]; n++)
            begin
                pick_item(ph == 2, op, ip, mac);
                sender_gap();
                drive_item(op, ip, mac, PREDICTED, EV_SEND, '0);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_events.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_events.size()));

        $display("covered %0d items (tick %0d, queue %0d, add %0d, lookup %0d) over %0d settings",
                 items_sent, op_seen[OP_TICK], op_seen[OP_QUEUE], op_seen[OP_ADD],
                 op_seen[OP_LOOKUP], settings_used);
        $display("%0d results: send %0d drop %0d hit %0d miss %0d release %0d ignored %0d full %0d",
                 results_seen, kind_seen[EV_SEND], kind_seen[EV_DROP], kind_seen[EV_HIT],
                 kind_seen[EV_MISS], kind_seen[EV_RELEASE], kind_seen[EV_IGNORED],
                 kind_seen[EV_FULL]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side back-pressure: random stall bursts, with calm stretches
    initial
    begin : result_sink
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_ready <= 1'b1;
            end
            else if (!steady_tail && !calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12);
                out_ready <= 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest awaited event
    always @(posedge clk)
    begin : result_check
        arp_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            kind_seen[event_kind]++;
            if (awaited_events.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d ip %h mac %h",
                                          event_kind, out_ip, out_mac));
            else
            begin
                want = awaited_events.pop_front();
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d (ip %h)",
                                              event_kind, want.kind, want.ip));
                if (out_ip !== want.ip)
                    report_mismatch($sformatf("out_ip %h, want %h", out_ip, want.ip));
                if (out_mac !== want.mac)
                    report_mismatch($sformatf("out_mac %h, want %h (ip %h)",
                                              out_mac, want.mac, want.ip));
                if (last_event !== want.last)
                    report_mismatch($sformatf("last_event %b, want %b (ip %h)",
                                              last_event, want.last, want.ip));
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_run = 0;
        else
        begin
            idle_run++;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_run);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
